@@ rtl/mei_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mei_pkg
// shared types and constants for the mandelbrot escape iteration block
// ----------------------------------------------------------------------------
package mei_pkg;

    localparam int DATA_W          = 32;   // Q4.28 operand width
    localparam int LIMIT_W         = 16;   // iteration limit register width
    localparam int RESULT_W        = 16;   // escape count field width
    localparam int FRAC_BITS_DEF   = 28;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1000;

    // one queued point with the limit it runs under
    typedef struct packed {
        logic signed [DATA_W-1:0] c_real;
        logic signed [DATA_W-1:0] c_imag;
        logic [LIMIT_W-1:0]       limit;
    } t_job;

endpackage

@@ rtl/mei_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mei interfaces
// point, result and configuration channels with valid / ready handshake
// ----------------------------------------------------------------------------
interface mei_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
    modport source (output valid, output c_real, output c_imag, input ready);
    modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

interface mei_count_if;
    logic        valid;
    logic        ready;
    logic [15:0] escape_count;
    modport source (output valid, output escape_count, input ready);
    modport sink   (input valid, input escape_count, output ready);
endinterface

interface mei_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] iteration_limit;
    modport source (output valid, output iteration_limit, input ready);
    modport sink   (input valid, input iteration_limit, output ready);
endinterface

@@ rtl/mei_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mei_front
// config register, limit clipping and a short queue of pending points
// ----------------------------------------------------------------------------
module mei_front #(
    parameter int COUNT_WIDTH = mei_pkg::COUNT_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mei_point_if.sink        i_point,
    mei_cfg_if.sink          i_cfg,
    output mei_pkg::t_job    o_job,
    output logic             o_job_valid,
    input  logic             i_job_ready
);
    import mei_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [LIMIT_W-1:0] r_limit;
    logic [LIMIT_W-1:0] w_limit_clip;
    t_job               r_queue [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [CNT_W-1:0]   r_fill;
    logic [CNT_W-1:0]   n_fill;
    logic               w_push;
    logic               w_pop;
    t_job               w_new;

    assign i_cfg.ready   = 1'b1;
    assign i_point.ready = (r_fill != FULL);
    assign w_push        = i_point.valid && i_point.ready;
    assign w_pop         = o_job_valid && i_job_ready;
    assign o_job_valid   = (r_fill != '0);
    assign o_job         = r_queue[r_rptr];

    // a limit beyond the counter range runs to the largest count
    assign w_limit_clip = ({17'd0, r_limit} > COUNT_MAX) ? COUNT_MAX[LIMIT_W-1:0] : r_limit;

    always_comb begin
        w_new.c_real = i_point.c_real;
        w_new.c_imag = i_point.c_imag;
        w_new.limit  = w_limit_clip;
        n_fill       = r_fill;
        if (w_push && !w_pop) begin
            n_fill = r_fill + CNT_W'(1);
        end else if (!w_push && w_pop) begin
            n_fill = r_fill - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_fill  <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_limit <= i_cfg.iteration_limit;
            end
            if (w_push) begin
                r_wptr <= (r_wptr == LAST) ? '0 : r_wptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == LAST) ? '0 : r_rptr + PTR_W'(1);
            end
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wptr] <= w_new;
        end
    end

    // fill level follows pushes and pops
    a_fill_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> r_fill == $past(r_fill) + CNT_W'(1))
        else $error("queue fill did not advance on push");

    // pointers are equal exactly when queue is empty or full
    a_ptr_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wptr == r_rptr) |-> (r_fill == '0 || r_fill == FULL))
        else $error("queue pointers disagree with fill");

    // queued limit never exceeds the counter range
    a_limit_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid |-> {17'd0, o_job.limit} <= COUNT_MAX)
        else $error("queued limit outside count range");

endmodule

@@ rtl/mei_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mei_engine
// iterates z = z*z + c for one point and holds the count until taken
// ----------------------------------------------------------------------------
module mei_engine #(
    parameter int FRAC_BITS   = mei_pkg::FRAC_BITS_DEF,
    parameter int COUNT_WIDTH = mei_pkg::COUNT_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mei_pkg::t_job    i_job,
    input  logic             i_job_valid,
    output logic             o_job_ready,
    mei_count_if.source      o_count
);
    import mei_pkg::*;

    localparam int SUM_W = (2 * FRAC_BITS + 3 > 65) ? 2 * FRAC_BITS + 3 : 65;
    localparam logic [SUM_W-1:0] BOUND =
        {{(SUM_W-3){1'b0}}, 3'd4} << (2 * FRAC_BITS);
    localparam logic signed [64:0] SAT_HI = 65'sd2147483647;
    localparam logic signed [64:0] SAT_LO = -65'sd2147483648;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_UPD  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                    r_state;
    t_state                    n_state;
    logic signed [DATA_W-1:0]  r_c_real;
    logic signed [DATA_W-1:0]  r_c_imag;
    logic [LIMIT_W-1:0]        r_limit;
    logic signed [DATA_W-1:0]  r_z_real;
    logic signed [DATA_W-1:0]  r_z_imag;
    logic [COUNT_WIDTH-1:0]    r_count;
    logic [63:0]               r_rr;
    logic [63:0]               r_ii;
    logic signed [63:0]        r_prod;
    logic [DATA_W-1:0]         w_mag_r;
    logic [DATA_W-1:0]         w_mag_i;
    logic [32:0]               w_count_ext;
    logic                      w_at_limit;
    logic [SUM_W-1:0]          w_sum;
    logic                      w_escape;
    logic signed [64:0]        w_diff;
    logic signed [64:0]        w_nr;
    logic signed [64:0]        w_ni;
    logic signed [DATA_W-1:0]  w_zr_next;
    logic signed [DATA_W-1:0]  w_zi_next;

    assign o_job_ready          = (r_state == S_IDLE);
    assign o_count.valid        = (r_state == S_DONE);
    assign w_count_ext          = {{(33-COUNT_WIDTH){1'b0}}, r_count};
    assign o_count.escape_count = w_count_ext[RESULT_W-1:0];
    assign w_at_limit           = (w_count_ext >= {17'd0, r_limit});

    // magnitudes, the most negative value maps to 2^31
    assign w_mag_r = r_z_real[DATA_W-1] ? (~r_z_real + 1'b1) : r_z_real;
    assign w_mag_i = r_z_imag[DATA_W-1] ? (~r_z_imag + 1'b1) : r_z_imag;

    assign w_sum    = {{(SUM_W-64){1'b0}}, r_rr} + {{(SUM_W-64){1'b0}}, r_ii};
    assign w_escape = (w_sum >= BOUND);
    assign w_diff   = $signed({1'b0, r_rr}) - $signed({1'b0, r_ii});
    assign w_nr     = (w_diff >>> FRAC_BITS)
                    + $signed({{33{r_c_real[DATA_W-1]}}, r_c_real});
    assign w_ni     = ($signed({r_prod[63], r_prod}) >>> (FRAC_BITS - 1))
                    + $signed({{33{r_c_imag[DATA_W-1]}}, r_c_imag});

    always_comb begin
        if (w_nr > SAT_HI) begin
            w_zr_next = SAT_HI[DATA_W-1:0];
        end else if (w_nr < SAT_LO) begin
            w_zr_next = SAT_LO[DATA_W-1:0];
        end else begin
            w_zr_next = w_nr[DATA_W-1:0];
        end
        if (w_ni > SAT_HI) begin
            w_zi_next = SAT_HI[DATA_W-1:0];
        end else if (w_ni < SAT_LO) begin
            w_zi_next = SAT_LO[DATA_W-1:0];
        end else begin
            w_zi_next = w_ni[DATA_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = w_at_limit ? S_DONE : S_UPD;
            end
            S_UPD: begin
                n_state = w_escape ? S_DONE : S_MUL;
            end
            S_DONE: begin
                if (o_count.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_z_real <= '0;
            r_z_imag <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_job_valid) begin
                r_count  <= '0;
                r_z_real <= '0;
                r_z_imag <= '0;
            end else if (r_state == S_UPD && !w_escape) begin
                r_count  <= r_count + COUNT_WIDTH'(1);
                r_z_real <= w_zr_next;
                r_z_imag <= w_zi_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_job_valid) begin
            r_c_real <= i_job.c_real;
            r_c_imag <= i_job.c_imag;
            r_limit  <= i_job.limit;
        end
        if (r_state == S_MUL) begin
            r_rr   <= {32'd0, w_mag_r} * {32'd0, w_mag_r};
            r_ii   <= {32'd0, w_mag_i} * {32'd0, w_mag_i};
            r_prod <= 64'(r_z_real) * 64'(r_z_imag);
        end
    end

    // an update step only runs below the limit
    a_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> (w_count_ext < {17'd0, r_limit}))
        else $error("iteration step past the limit");

    // a step that does not escape advances the count by one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && !w_escape) |=> (r_count == $past(r_count) + COUNT_WIDTH'(1)))
        else $error("count did not advance");

    // the finished count never exceeds the limit it ran under
    a_result_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_count.valid |-> (w_count_ext <= {17'd0, r_limit}))
        else $error("result beyond limit");

endmodule

@@ rtl/mandelbrot_escape_iteration.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_iteration
// escape-time counter for one Q4.28 point c per word
// ----------------------------------------------------------------------------
// A point c arrives as a signed Q4.28 real and imaginary pair on i_point and
// the block returns on o_count the number of steps of z = z*z + c (from z = 0)
// taken before |z|^2 reaches 4, or the iteration limit if it never does. The
// limit is written through i_cfg (reset 1000); the user must write it only
// while the block is idle, which the block itself does not enforce. A limit
// of 0 returns 0 at once. A front queue of two points takes words while the
// engine works, so the source sees no stall until the queue fills. Each step
// runs in the iteration engine through S_MUL, for the three 32x32 products,
// then S_UPD, for the escape test and the floor, add and saturate update.
// The engine holds one point at a time and takes its next point only after
// the result word goes out, so the sustained rate is set by that single
// engine.
// ----------------------------------------------------------------------------
module mandelbrot_escape_iteration #(
    parameter int FRAC_BITS   = mei_pkg::FRAC_BITS_DEF,
    parameter int COUNT_WIDTH = mei_pkg::COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mei_point_if.sink   i_point,
    mei_cfg_if.sink     i_cfg,
    mei_count_if.source o_count
);
    import mei_pkg::*;

    // point handed from the queue to the engine
    t_job w_job;
    logic w_job_valid;
    logic w_job_ready;

    // front: limit register, clipping, queue of pending points
    mei_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_point     (i_point),
        .i_cfg       (i_cfg),
        .o_job       (w_job),
        .o_job_valid (w_job_valid),
        .i_job_ready (w_job_ready)
    );

    // back: iteration engine with its own result register
    mei_engine #(
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job),
        .i_job_valid (w_job_valid),
        .o_job_ready (w_job_ready),
        .o_count     (o_count)
    );

endmodule

@@ test/tb_mandelbrot_escape_iteration.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_iteration
// self-checking bench for the fixed-point mandelbrot escape counter
// ----------------------------------------------------------------------------
// A short directed list of points (range corners, the exact escape radius,
// bounded orbits, limit of zero, one and the maximum) runs first, then eight
// random phases, each under its own iteration limit. Each accepted point's
// count is queued, typed in where known, else from a bit-exact Q4.28 iteration
// model. Each count word is checked against the oldest queued count. Both
// sides pause at random, and once the count sink holds off for a long
// stretch so that the point queue fills and the point channel stalls.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_iteration;

    import mei_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;

    // run limit: a 65535-step point, plus every other point at its worst
    // under a 1000 limit, each with the longest gaps and stalls, taken a
    // few times over
    localparam int RUN_LIMIT    = 4_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASES       = 8;
    localparam int PHASE_POINTS = 50;

    localparam logic [63:0] ESCAPE_BOUND = 64'd4 << (2 * FRAC);
    localparam longint      SAT_HI       = 64'sh7FFF_FFFF;
    localparam longint      SAT_LO       = -64'sh8000_0000;

    // Q4.28 values used in the directed list
    localparam logic signed [31:0] C_ZERO    = 32'sh0000_0000;
    localparam logic signed [31:0] C_ONE     = 32'sh1000_0000;
    localparam logic signed [31:0] C_TWO     = 32'sh2000_0000;
    localparam logic signed [31:0] C_NEG_ONE = 32'shF000_0000;
    localparam logic signed [31:0] C_NEG_TWO = 32'shE000_0000;
    localparam logic signed [31:0] C_MIN     = 32'sh8000_0000;
    localparam logic signed [31:0] C_MAX     = 32'sh7FFF_FFFF;

    // one directed point; the count is typed in only where known is set
    typedef struct packed {
        logic [LIMIT_W-1:0]       limit;
        logic signed [DATA_W-1:0] c_real;
        logic signed [DATA_W-1:0] c_imag;
        logic                     known;
        logic [RESULT_W-1:0]      count;
    } t_probe;

    localparam int N_PROBES = 23;
    localparam t_probe PROBES [N_PROBES] = '{
        // reset limit: origin never escapes
        '{16'd1000,  C_ZERO,        C_ZERO,        1'b1, 16'd1000},
        // corners of the operand range escape after the first step
        '{16'd1000,  C_MIN,         C_MIN,         1'b1, 16'd1},
        '{16'd1000,  C_MAX,         C_MAX,         1'b1, 16'd1},
        '{16'd1000,  C_MIN,         C_MAX,         1'b1, 16'd1},
        '{16'd1000,  C_MAX,         C_ZERO,        1'b1, 16'd1},
        '{16'd1000,  C_ZERO,        C_MIN,         1'b1, 16'd1},
        // |z|^2 exactly 4 counts as escaped
        '{16'd1000,  C_TWO,         C_ZERO,        1'b1, 16'd1},
        '{16'd1000,  C_NEG_TWO,     C_ZERO,        1'b1, 16'd1},
        '{16'd1000,  C_ZERO,        C_TWO,         1'b1, 16'd1},
        // exact period-two orbits stay bounded
        '{16'd1000,  C_NEG_ONE,     C_ZERO,        1'b1, 16'd1000},
        '{16'd1000,  C_ZERO,        C_ONE,         1'b1, 16'd1000},
        // cusp neighborhood and boundary points, counts from the model
        '{16'd1000,  32'sh0400_0000, C_ZERO,       1'b0, 16'd0},
        '{16'd1000,  32'sh0428_F5C2, C_ZERO,       1'b0, 16'd0},
        '{16'd1000,  32'shF400_0000, 32'sh0199_999A, 1'b0, 16'd0},
        '{16'd1000,  32'shE800_0000, C_ZERO,       1'b0, 16'd0},
        '{16'd1000,  32'sh04CC_CCCD, 32'sh0800_0000, 1'b0, 16'd0},
        // limit of zero takes no step
        '{16'd0,     C_ZERO,        C_ZERO,        1'b1, 16'd0},
        '{16'd0,     C_MAX,         C_MIN,         1'b1, 16'd0},
        // limit of one always takes exactly one step
        '{16'd1,     C_ZERO,        C_ZERO,        1'b1, 16'd1},
        '{16'd1,     C_MIN,         C_MIN,         1'b1, 16'd1},
        '{16'd2,     C_ONE,         C_ZERO,        1'b0, 16'd0},
        // largest limit
        '{16'hFFFF,  C_ZERO,        C_ZERO,        1'b1, 16'hFFFF},
        '{16'hFFFF,  C_MIN,         C_ZERO,        1'b1, 16'd1}
    };

    logic i_clk;
    logic i_rst_n;

    mei_point_if point_bus ();
    mei_cfg_if   cfg_bus ();
    mei_count_if count_bus ();

    mandelbrot_escape_iteration u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_point (point_bus),
        .i_cfg   (cfg_bus),
        .o_count (count_bus)
    );

    // counts predicted for accepted points, oldest first
    logic [RESULT_W-1:0] expected_counts [$];
    logic [LIMIT_W-1:0]  limit_now;
    int                  fail_count;
    int                  cycle_count;
    bit                  source_steady;  // no gaps between point words
    bit                  sink_steady;    // count sink never stalls
    bit                  hold_req;       // ask the sink for one long hold-off

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // clamp to the 32-bit Q4.28 range
    function automatic logic signed [31:0] sat_q428(input longint v);
        if (v > SAT_HI) return 32'sh7FFF_FFFF;
        if (v < SAT_LO) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // escape-time count for point c under the given limit, bit exact:
    // exact Q8.56 squares for the test, floored back to Q4.28, plus c, clamped
    function automatic logic [RESULT_W-1:0] escape_steps(
        input logic signed [31:0] cr,
        input logic signed [31:0] ci,
        input logic [LIMIT_W-1:0] limit
    );
        logic signed [31:0] zr;
        logic signed [31:0] zi;
        logic [63:0]        ar;
        logic [63:0]        ai;
        logic [63:0]        rr;
        logic [63:0]        ii;
        longint             diff;
        longint             prod;
        int unsigned        steps;
        zr    = '0;
        zi    = '0;
        steps = 0;
        while (steps < limit) begin
            ar = (zr < 0) ? 64'(-longint'(zr)) : 64'(longint'(zr));
            ai = (zi < 0) ? 64'(-longint'(zi)) : 64'(longint'(zi));
            rr = ar * ar;
            ii = ai * ai;
            if (rr + ii >= ESCAPE_BOUND) break;
            diff = longint'(rr) - longint'(ii);
            // 2*zr*zi is the product floored by one bit less
            prod = longint'(zr) * longint'(zi);
            zr   = sat_q428((diff >>> FRAC) + longint'(cr));
            zi   = sat_q428((prod >>> (FRAC - 1)) + longint'(ci));
            steps++;
        end
        return 16'(steps);
    endfunction

    // idle cycles before the next point word: mostly none, some short, few long
    function automatic int pick_gap();
        int roll;
        if (source_steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one point word, hold it until taken, then queue its count;
    // valid stays high across back-to-back words
    task automatic offer_point(
        input logic signed [31:0] cr,
        input logic signed [31:0] ci,
        input int                 gap,
        input logic [RESULT_W-1:0] want
    );
        if (gap > 0) begin
            point_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        point_bus.valid  <= 1'b1;
        point_bus.c_real <= cr;
        point_bus.c_imag <= ci;
        do @(posedge i_clk); while (point_bus.ready !== 1'b1);
        expected_counts.push_back(want);
    endtask

    // write the limit once every outstanding count is back
    task automatic set_limit(input logic [LIMIT_W-1:0] value);
        while (expected_counts.size() != 0) @(posedge i_clk);
        cfg_bus.valid           <= 1'b1;
        cfg_bus.iteration_limit <= value;
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        cfg_bus.valid <= 1'b0;
        limit_now = value;
    endtask

    // run limit
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // count sink: check each word taken, then choose ready for the next cycle
    initial begin : count_sink
        int                  stall_left;
        int                  hold_left;
        logic [RESULT_W-1:0] want;
        stall_left = 0;
        hold_left  = 0;
        count_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && count_bus.valid === 1'b1 && count_bus.ready === 1'b1) begin
                if (expected_counts.size() == 0) begin
                    $error("escape_count word %0d with nothing expected",
                           count_bus.escape_count);
                    fail_count++;
                end else begin
                    want = expected_counts.pop_front();
                    if (count_bus.escape_count !== want) begin
                        $error("escape_count: expected %0d, actual %0d",
                               want, count_bus.escape_count);
                        fail_count++;
                    end
                end
            end
            // long hold-off so the point queue fills behind it
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (!i_rst_n) begin
                count_bus.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                count_bus.ready <= 1'b0;
            end else if (sink_steady) begin
                count_bus.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                count_bus.ready <= 1'b0;
            end else begin
                count_bus.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                            : $urandom_range(1, 3);
                end
            end
        end
    end

    // point source, limit writes and end of run
    initial begin : point_source
        logic signed [31:0] cr;
        logic signed [31:0] ci;
        logic [LIMIT_W-1:0] lim;
        fail_count    = 0;
        limit_now     = LIMIT_RESET;
        source_steady = 1'b0;
        sink_steady   = 1'b0;
        hold_req      = 1'b0;

        i_rst_n                 <= 1'b0;
        point_bus.valid         <= 1'b0;
        point_bus.c_real        <= '0;
        point_bus.c_imag        <= '0;
        cfg_bus.valid           <= 1'b0;
        cfg_bus.iteration_limit <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed list, first rows run under the reset limit
        for (int i = 0; i < N_PROBES; i++) begin
            if (PROBES[i].limit != limit_now) begin
                point_bus.valid <= 1'b0;
                set_limit(PROBES[i].limit);
            end
            offer_point(PROBES[i].c_real, PROBES[i].c_imag, pick_gap(),
                        PROBES[i].known ? PROBES[i].count
                                        : escape_steps(PROBES[i].c_real,
                                                       PROBES[i].c_imag, limit_now));
        end

        // random phases, each under a limit of its own
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       lim = 16'hFFFF;
                1:       lim = 16'd0;
                2:       lim = 16'd1;
                3:       lim = 16'($urandom_range(2, 40));
                4:       lim = 16'($urandom_range(41, 300));
                5:       lim = 16'($urandom_range(301, 1000));
                6:       lim = 16'($urandom_range(2, 1000));
                default: lim = LIMIT_RESET;
            endcase
            point_bus.valid <= 1'b0;
            set_limit(lim);
            source_steady = (phase == 2 || phase == 4);
            sink_steady   = (phase == 3 || phase == 6);
            // sender keeps offering back to back while the sink holds off
            if (phase == 2) hold_req = 1'b1;

            for (int n = 0; n < PHASE_POINTS; n++) begin
                if (phase == 0) begin
                    // |c_real| >= 2 so the largest limit still ends at once
                    cr = $urandom;
                    ci = $urandom;
                    if (cr[31:29] == 3'b000 || cr[31:29] == 3'b111) cr[30] = ~cr[30];
                end else if ($urandom_range(0, 4) == 0) begin
                    // anywhere in the operand range
                    cr = $urandom;
                    ci = $urandom;
                end else begin
                    // real in [-2.0, 0.5], imag in [-1.25, 1.25]
                    cr = int'($urandom_range(0, 671088640)) - 536870912;
                    ci = int'($urandom_range(0, 671088640)) - 335544320;
                end
                offer_point(cr, ci, pick_gap(), escape_steps(cr, ci, limit_now));
            end
        end

        point_bus.valid <= 1'b0;
        while (expected_counts.size() != 0) @(posedge i_clk);
        // room for any stray count word to show up
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule
